>>> sv/mexp_pkg.sv
// Shared widths and constants for the modular exponentiation block.
package mexp_pkg;

  localparam int MOD_WIDTH   = 31;
  localparam int EXP_WIDTH   = 32;
  localparam int IN_TDATA_W  = ((MOD_WIDTH + EXP_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MOD_WIDTH + 7) / 8) * 8;
  localparam int CNT_W       = $clog2(MOD_WIDTH);

  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(1000000007);

endpackage

>>> sv/modular_exponentiation.sv
// Modular exponentiation top level: right-to-left square-and-multiply, bit-serial multiplier.
// A zero exponent goes from the input beat to ST_HOLD, then to the output register. Otherwise the item
// takes 1 + popcount(e) + (bitlength(e) - 1) modular multiplies, all on the single shared
// interleaved multiply-reduce unit; up to 64 multiplies.
// One item in work at a time: a new beat is taken only back in ST_IDLE, which an out stall delays.
// Reset (rst_n low, synchronous) empties the block and sets the modulus to 1000000007.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // cfg_data: modulus
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MOD_WIDTH-1:0]   cfg_data,
  // in_tdata: base, exponent, zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: result, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_HOLD} state_t;
  typedef enum logic [1:0] {OP_RED, OP_XP, OP_SQ} op_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [MOD_WIDTH-1:0] m_r, m_nxt;
  logic [MOD_WIDTH-1:0] x_r, x_nxt;
  logic [MOD_WIDTH-1:0] p_r, p_nxt;
  logic [EXP_WIDTH-1:0] n_r, n_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic [MOD_WIDTH-1:0] mcand_r, mcand_nxt;
  logic [MOD_WIDTH-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MOD_WIDTH-1:0] res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [MOD_WIDTH-1:0] in_base;
  logic [EXP_WIDTH-1:0] in_exponent;
  logic                 in_beat;
  logic [MOD_WIDTH+1:0] step_sum;
  logic [MOD_WIDTH+2:0] diff1, diff2;
  logic [MOD_WIDTH-1:0] acc_step;
  logic                 last_step;
  logic [MOD_WIDTH-1:0] x_w, p_w;
  logic [EXP_WIDTH-1:0] n_w;
  logic                 fin;

  assign in_base     = in_tdata[MOD_WIDTH-1:0];
  assign in_exponent = in_tdata[MOD_WIDTH+EXP_WIDTH-1:MOD_WIDTH];
  assign in_tready   = (state_r == ST_IDLE);
  assign in_beat     = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = {{(OUT_TDATA_W-MOD_WIDTH){1'b0}}, res_r};

  // one step of the interleaved multiply: acc = (2*acc + bit*mcand) mod m
  always_comb begin
    step_sum = {1'b0, acc_r, 1'b0}
             + (mplier_r[MOD_WIDTH-1] ? {2'b00, mcand_r} : {(MOD_WIDTH+2){1'b0}});
    diff1 = {1'b0, step_sum} - {3'b000, m_r};
    diff2 = {1'b0, step_sum} - {2'b00, m_r, 1'b0};
    if (!diff2[MOD_WIDTH+2]) begin
      acc_step = diff2[MOD_WIDTH-1:0];
    end else if (!diff1[MOD_WIDTH+2]) begin
      acc_step = diff1[MOD_WIDTH-1:0];
    end else begin
      acc_step = step_sum[MOD_WIDTH-1:0];
    end
  end

  assign last_step = (cnt_r == CNT_W'(MOD_WIDTH - 1));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    m_nxt         = m_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    x_w           = x_r;
    p_w           = p_r;
    n_w           = n_r;
    fin           = 1'b0;

    if (cfg_valid && (cfg_data != '0)) begin
      m_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          n_nxt = in_exponent;
          x_nxt = MOD_WIDTH'(1);
          if (in_exponent == '0) begin
            state_nxt = ST_HOLD;
          end else begin
            op_nxt     = OP_RED;
            mcand_nxt  = MOD_WIDTH'(1);
            mplier_nxt = in_base;
            acc_nxt    = '0;
            cnt_nxt    = '0;
            state_nxt  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_nxt    = acc_step;
        cnt_nxt    = cnt_r + CNT_W'(1);
        mplier_nxt = {mplier_r[MOD_WIDTH-2:0], 1'b0};
        if (last_step) begin
          unique case (op_r)
            OP_RED: p_w = acc_step;
            OP_XP: begin
              x_w = acc_step;
              fin = ((n_r >> 1) == '0);
            end
            OP_SQ: begin
              p_w = acc_step;
              n_w = n_r >> 1;
            end
            default: p_w = p_r;
          endcase
          x_nxt   = x_w;
          p_nxt   = p_w;
          n_nxt   = n_w;
          acc_nxt = '0;
          cnt_nxt = '0;
          if (fin) begin
            state_nxt = ST_HOLD;
          end else if ((op_r != OP_XP) && n_w[0]) begin
            op_nxt     = OP_XP;
            mcand_nxt  = x_w;
            mplier_nxt = p_w;
          end else begin
            op_nxt     = OP_SQ;
            mcand_nxt  = p_w;
            mplier_nxt = p_w;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          res_nxt       = x_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_RED;
      m_r         <= MODULUS_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      m_r         <= m_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r      <= x_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    res_r    <= res_nxt;
  end

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_MUL) |-> (cnt_r == '0))
    else $error("step counter not cleared outside multiply");

  a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (n_r != '0))
    else $error("multiply running with exhausted exponent");

  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_exponent == '0)) |=> (state_r == ST_HOLD) && (x_r == MOD_WIDTH'(1)))
    else $error("zero exponent did not go straight to result");

  a_hold_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && (!out_valid_r || out_tready)) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished result not loaded into output register");

endmodule

>>> sim/tb_top.sv
// Self-checking bench for modular_exponentiation: directed table, then random modulus phases.
module tb_top
  import mexp_pkg::*;
();

  typedef enum logic {ROW_ITEM, ROW_MOD} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [MOD_WIDTH-1:0]  value;
    logic [EXP_WIDTH-1:0]  exponent;
    logic                  typed;
    logic [MOD_WIDTH-1:0]  result;
  } stim_row_t;

  localparam int N_DIR       = 25;
  localparam int N_RANDOM    = 270;
  localparam int HOLD_CYCLES = 600;
  localparam logic [MOD_WIDTH-1:0] MOD_MAX = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [MOD_WIDTH-1:0]   cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [MOD_WIDTH-1:0] modulus_model;
  logic [MOD_WIDTH-1:0] powmod_q[$];
  logic [MOD_WIDTH-1:0] want_result;
  int                   error_count;
  bit                   hold_off_req;
  bit                   sender_gaps;

  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_ITEM, 31'h0,        32'h0,        1'b1, 31'd1},
    '{ROW_ITEM, 31'h7FFFFFFF, 32'h0,        1'b1, 31'd1},
    '{ROW_ITEM, 31'd2,        32'd10,       1'b1, 31'd1024},
    '{ROW_ITEM, 31'h0,        32'd5,        1'b1, 31'd0},
    '{ROW_ITEM, 31'd1,        32'hFFFFFFFF, 1'b1, 31'd1},
    '{ROW_ITEM, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, 31'd0},
    '{ROW_ITEM, 31'h7FFFFFFF, 32'd1,        1'b1, 31'd147483633},
    '{ROW_ITEM, 31'd1000000007, 32'd1,      1'b1, 31'd0},
    '{ROW_ITEM, 31'd1000000006, 32'd2,      1'b1, 31'd1},
    '{ROW_ITEM, 31'd3,        32'h80000000, 1'b0, 31'd0},
    '{ROW_ITEM, 31'd12345,    32'h55555555, 1'b0, 31'd0},
    '{ROW_ITEM, 31'h2AAAAAAA, 32'hAAAAAAAA, 1'b0, 31'd0},
    '{ROW_MOD,  31'd1,        32'h0,        1'b0, 31'd0},
    '{ROW_ITEM, 31'd5,        32'h0,        1'b1, 31'd1},
    '{ROW_ITEM, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 31'd0},
    '{ROW_ITEM, 31'h0,        32'd1,        1'b1, 31'd0},
    '{ROW_MOD,  31'd0,        32'h0,        1'b0, 31'd0},
    '{ROW_ITEM, 31'd7,        32'd3,        1'b1, 31'd0},
    '{ROW_MOD,  31'h7FFFFFFF, 32'h0,        1'b0, 31'd0},
    '{ROW_ITEM, 31'h7FFFFFFF, 32'd1,        1'b1, 31'd0},
    '{ROW_ITEM, 31'h7FFFFFFE, 32'd2,        1'b1, 31'd1},
    '{ROW_ITEM, 31'h7FFFFFFE, 32'hFFFFFFFF, 1'b0, 31'd0},
    '{ROW_MOD,  31'd2,        32'h0,        1'b0, 31'd0},
    '{ROW_ITEM, 31'd3,        32'd7,        1'b1, 31'd1},
    '{ROW_ITEM, 31'h7FFFFFFF, 32'hAAAAAAAA, 1'b0, 31'd0}
  };

  modular_exponentiation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                         input logic [MOD_WIDTH-1:0] m);
    logic [63:0] prod;
    prod = a * b;
    return (prod >= 64'(m)) ? prod % 64'(m) : prod;
  endfunction

  function automatic logic [MOD_WIDTH-1:0] modpow(input logic [MOD_WIDTH-1:0] b,
                                                  input logic [EXP_WIDTH-1:0] e,
                                                  input logic [MOD_WIDTH-1:0] m);
    logic [63:0] acc;
    logic [63:0] pw;
    acc = 64'd1;
    pw  = 64'(b);
    for (int i = 0; i < EXP_WIDTH; i++) begin
      if (e[i]) begin
        acc = mulmod(acc, pw, m);
      end
      pw = mulmod(pw, pw, m);
    end
    return acc[MOD_WIDTH-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MOD_WIDTH-1:0] rand_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MOD_WIDTH'(1);
      2: return modulus_model - 1'b1;
      3: return modulus_model + MOD_WIDTH'($urandom_range(0, 1000));
      4: return MOD_WIDTH'($urandom_range(2, 1000));
      default: return MOD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [EXP_WIDTH-1:0] rand_exponent(input bit small_only);
    int r;
    int w;
    logic [EXP_WIDTH-1:0] e;
    if (small_only) return EXP_WIDTH'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    w = (r < 70) ? $urandom_range(1, 10) : (r < 90) ? $urandom_range(11, 31) : EXP_WIDTH;
    e = EXP_WIDTH'($urandom);
    e = e & ({EXP_WIDTH{1'b1}} >> (EXP_WIDTH - w));
    e[w-1] = 1'b1;
    return e;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // hold input low until every expected beat has come back
  task automatic drain();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
    end
    while (powmod_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_WIDTH-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (value != '0) begin
      modulus_model = value;
    end
  endtask

  task automatic push_item(input logic [MOD_WIDTH-1:0] base, input logic [EXP_WIDTH-1:0] expo,
                           input logic typed, input logic [MOD_WIDTH-1:0] typed_result);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({expo, base});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    powmod_q.push_back(typed ? typed_result : modpow(base, expo, modulus_model));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (powmod_q.size() == 0) begin
        report_error($sformatf("result %0d with none expected", out_tdata[MOD_WIDTH-1:0]));
      end else begin
        want_result = powmod_q.pop_front();
        if (out_tdata[MOD_WIDTH-1:0] !== want_result) begin
          report_error($sformatf("result %0d, expected %0d",
                                 out_tdata[MOD_WIDTH-1:0], want_result));
        end
      end
    end
  end

  initial begin
    int run_len;
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= 1'b1;
      run_len = $urandom_range(1, 24);
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    logic [MOD_WIDTH-1:0] next_mod;
    int sent;
    int phase;
    int phase_len;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    error_count   = 0;
    hold_off_req  = 1'b0;
    sender_gaps   = 1'b1;
    modulus_model = MODULUS_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_MOD) begin
        write_modulus(dir_rows[i].value);
      end else begin
        push_item(dir_rows[i].value, dir_rows[i].exponent, dir_rows[i].typed,
                  dir_rows[i].result);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      case ($urandom_range(0, 7))
        0: next_mod = MOD_WIDTH'(1);
        1: next_mod = MOD_WIDTH'(2);
        2: next_mod = MOD_MAX;
        3: next_mod = '0;
        4: next_mod = MODULUS_RESET;
        5: next_mod = MOD_WIDTH'($urandom_range(3, 1000));
        default: next_mod = MOD_WIDTH'($urandom);
      endcase
      write_modulus(next_mod);
      phase_len   = $urandom_range(15, 40);
      sender_gaps = ($urandom_range(0, 3) != 0);
      // stall the receiver while short items keep coming, so the input backs up
      if (phase == 0) begin
        hold_off_req = 1'b1;
        sender_gaps  = 1'b0;
      end
      for (int i = 0; i < phase_len && sent < N_RANDOM; i++) begin
        if (phase == 1 && i == phase_len / 2) begin
          drain();
        end
        push_item(rand_base(), rand_exponent(phase == 0), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain();
    repeat (3000) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/mexp_pkg.sv
sv/modular_exponentiation.sv
sim/tb_top.sv
